### rtl/lrdi_pkg.sv
// shared types and constants for the line rasterizer with depth interpolation
`default_nettype none

package lrdi_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ROW_STRIDE      = 1'b0,
    REG_BYTES_PER_PIXEL = 1'b1
  } cfg_reg_t;

  localparam logic [15:0] ROW_STRIDE_RESET      = 16'd4096;
  localparam logic [3:0]  BYTES_PER_PIXEL_RESET = 4'd4;

  // input word kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // one pixel leaving the stepper
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] depth;
    logic        in_range;
    logic        last;
  } pix_t;

endpackage

`default_nettype wire

### rtl/lrdi_stepper.sv
// bresenham line state and first pipeline stage (pixel position, depth, range check)
`default_nettype none

module lrdi_stepper #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  wire  [151:0]      s_tdata,
  input  wire               s_tuser,
  output logic              pix_valid,
  input  wire               pix_ready,
  output lrdi_pkg::pix_t    pix
);
  import lrdi_pkg::*;

  // line state
  logic signed [15:0] major_pos;
  logic signed [15:0] minor_pos;
  logic signed [15:0] major_end;
  logic [15:0]        span_major;
  logic [15:0]        span_minor;
  logic [17:0]        step_error;
  logic [31:0]        depth_acc;
  logic [31:0]        depth_inc;
  logic               axes_swapped;
  logic               step_down;
  logic               line_active;

  // input field unpacking
  logic signed [15:0] in_start_major;
  logic signed [15:0] in_start_minor;
  logic signed [15:0] in_end_major;
  logic [15:0]        in_major_span;
  logic [15:0]        in_minor_span;
  logic               in_steep;
  logic               in_minor_down;
  logic [31:0]        in_depth_start;
  logic [31:0]        in_depth_step;

  assign in_start_major = s_tdata[15:0];
  assign in_start_minor = s_tdata[31:16];
  assign in_end_major   = s_tdata[47:32];
  assign in_major_span  = s_tdata[63:48];
  assign in_minor_span  = s_tdata[79:64];
  assign in_steep       = s_tdata[80];
  assign in_minor_down  = s_tdata[81];
  assign in_depth_start = s_tdata[113:82];
  assign in_depth_step  = s_tdata[145:114];

  logic s_fire;
  logic step_fire;
  logic start_fire;

  assign s_tready   = !pix_valid || pix_ready;
  assign s_fire     = s_tvalid && s_tready;
  assign start_fire = s_fire && (s_tuser == KIND_START);
  assign step_fire  = s_fire && (s_tuser == KIND_STEP) && line_active;

  // current pixel position and range check
  logic [15:0] cur_x;
  logic [15:0] cur_y;
  logic        cur_in_range;
  logic        cur_last;

  always_comb begin
    cur_x = axes_swapped ? minor_pos : major_pos;
    cur_y = axes_swapped ? major_pos : minor_pos;
    cur_in_range = !cur_x[15] && !cur_y[15] &&
                   (cur_x < 16'(SCREEN_WIDTH)) && (cur_y < 16'(SCREEN_HEIGHT));
    cur_last = (major_pos == major_end);
  end

  // error term, minor step and saturating depth for the next pixel
  logic [17:0]        err_sub;
  logic [17:0]        err_next;
  logic signed [15:0] minor_next;
  logic [32:0]        depth_sum;
  logic [31:0]        depth_next;

  always_comb begin
    err_sub    = step_error - {2'b00, span_minor};
    err_next   = err_sub;
    minor_next = minor_pos;
    if (err_sub[17]) begin
      err_next   = err_sub + {2'b00, span_major};
      minor_next = step_down ? minor_pos - 16'sd1 : minor_pos + 16'sd1;
    end
    depth_sum = {depth_acc[31], depth_acc} + {depth_inc[31], depth_inc};
    if (depth_sum[32] != depth_sum[31]) begin
      depth_next = depth_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      depth_next = depth_sum[31:0];
    end
  end

  // line state update
  always_ff @(posedge clk) begin
    if (rst) begin
      major_pos    <= '0;
      minor_pos    <= '0;
      major_end    <= '0;
      span_major   <= '0;
      span_minor   <= '0;
      step_error   <= '0;
      depth_acc    <= '0;
      depth_inc    <= '0;
      axes_swapped <= 1'b0;
      step_down    <= 1'b0;
      line_active  <= 1'b0;
    end else if (start_fire) begin
      major_pos    <= in_start_major;
      minor_pos    <= in_start_minor;
      major_end    <= in_end_major;
      span_major   <= in_major_span;
      span_minor   <= in_minor_span;
      step_error   <= {3'b000, in_major_span[15:1]};
      depth_acc    <= in_depth_start;
      depth_inc    <= in_depth_step;
      axes_swapped <= in_steep;
      step_down    <= in_minor_down;
      line_active  <= (in_start_major <= in_end_major);
    end else if (step_fire) begin
      step_error <= err_next;
      minor_pos  <= minor_next;
      depth_acc  <= depth_next;
      if (cur_last) begin
        line_active <= 1'b0;
      end else begin
        major_pos <= major_pos + 16'sd1;
      end
    end
  end

  // stage register toward the address unit
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s_tready) begin
      pix_valid <= step_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      pix.x        <= cur_x;
      pix.y        <= cur_y;
      pix.depth    <= depth_acc;
      pix.in_range <= cur_in_range;
      pix.last     <= cur_last;
    end
  end

`ifndef SYNTHESIS
  // a stalled pixel keeps its contents
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pix))
    else $error("stalled pixel changed");

  // a step with no line in progress yields no pixel
  a_no_line: assert property (@(posedge clk) disable iff (rst)
    s_fire && (s_tuser == KIND_STEP) && !line_active |=> !pix_valid)
    else $error("pixel emitted without an active line");

  // the final pixel ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    step_fire && cur_last |=> !line_active && pix_valid && pix.last)
    else $error("line still active after last pixel");
`endif

endmodule

`default_nettype wire

### rtl/lrdi_pixel_addr.sv
// framebuffer offset products, bound check and output register
`default_nettype none

module lrdi_pixel_addr #(
  parameter int SCREEN_HEIGHT = 768
) (
  input  wire               clk,
  input  wire               rst,
  input  wire  [15:0]       row_stride_bytes,
  input  wire  [3:0]        bytes_per_pixel,
  input  wire               pix_valid,
  output logic              pix_ready,
  input  lrdi_pkg::pix_t    pix,
  output logic              m_tvalid,
  input  wire               m_tready,
  output logic [103:0]      m_tdata,
  output logic              m_tlast
);
  import lrdi_pkg::*;

  // product stage
  logic        prod_valid;
  logic        prod_ready;
  pix_t        prod_pix;
  logic [31:0] prod_y;
  logic [19:0] prod_x;
  logic [31:0] prod_limit;

  // output register
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [31:0] out_offset;
  logic [31:0] out_depth;
  logic        out_visible;
  logic        out_last;

  assign prod_ready = !m_tvalid || m_tready;
  assign pix_ready  = !prod_valid || prod_ready;

  // row and column products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (pix_ready) begin
      prod_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      prod_pix   <= pix;
      prod_y     <= pix.y * row_stride_bytes;
      prod_x     <= pix.x * bytes_per_pixel;
      prod_limit <= 32'(row_stride_bytes) * 32'(SCREEN_HEIGHT);
    end
  end

  // offset sum and buffer bound
  logic [31:0] offset_sum;
  logic        vis;

  always_comb begin
    offset_sum = prod_y + {12'd0, prod_x};
    vis        = prod_pix.in_range && (offset_sum < prod_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (prod_ready) begin
      m_tvalid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) begin
      out_x       <= prod_pix.x;
      out_y       <= prod_pix.y;
      out_offset  <= vis ? offset_sum : 32'd0;
      out_depth   <= prod_pix.depth;
      out_visible <= vis;
      out_last    <= prod_pix.last;
    end
  end

  assign m_tdata = {7'd0, out_visible, out_depth, out_offset, out_y, out_x};
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  // hidden pixels carry a zero offset
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_visible |-> out_offset == 32'd0)
    else $error("nonzero offset on hidden pixel");

  // a visible pixel lies inside the buffer bound
  a_vis_bound: assert property (@(posedge clk) disable iff (rst)
    prod_valid && vis |-> offset_sum < prod_limit && prod_pix.in_range)
    else $error("visible pixel outside bound");

  // a stalled product stage keeps its word
  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    prod_valid && !prod_ready |=> prod_valid && $stable(prod_pix))
    else $error("stalled product stage changed");
`endif

endmodule

`default_nettype wire

### rtl/line_rasterizer_depth_interp_unit.sv
// top level of the bresenham line rasterizer with depth interpolation
`default_nettype none

// Bresenham line stepper with Q16.16 depth. A start word (tuser 0) loads a
// prepared line and yields no pixel; each step word (tuser 1) yields one pixel
// while a line is active, with screen x/y, framebuffer byte offset, depth, a
// visible flag and tlast on the final pixel. One word is taken per clock unless
// the input stalls. A pixel passes three registered stages: the stepper (pixel
// position, range check, error term, minor step, saturating depth add), the
// row and column multiplies and the offset add and buffer bound compare. Each
// stage has its own ready, so while a pixel waits at the output the stages
// behind it still fill; the input stalls, start words included, once all three
// stages hold a pixel and the output is not ready.
// Configuration writes are taken every cycle and must be made while idle.
module line_rasterizer_depth_interp_unit #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  wire          clk,
  input  wire          rst,
  // configuration write channel
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [0:0]   cfg_index,
  input  wire  [15:0]  cfg_data,
  // input words
  input  wire          s_tvalid,
  output logic         s_tready,
  // start_major, start_minor, end_major, major_span, minor_span, steep,
  // minor_down, depth_start, depth_step
  input  wire  [151:0] s_tdata,
  // kind
  input  wire          s_tuser,
  // pixel words
  output logic         m_tvalid,
  input  wire          m_tready,
  // pixel_x, pixel_y, byte_offset, depth, visible
  output logic [103:0] m_tdata,
  output logic         m_tlast
);
  import lrdi_pkg::*;

  logic [15:0] row_stride_bytes;
  logic [3:0]  bytes_per_pixel;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride_bytes <= ROW_STRIDE_RESET;
      bytes_per_pixel  <= BYTES_PER_PIXEL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_STRIDE:      row_stride_bytes <= cfg_data;
        REG_BYTES_PER_PIXEL: bytes_per_pixel  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic pix_valid;
  logic pix_ready;
  pix_t pix;

  lrdi_stepper #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_stepper (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  lrdi_pixel_addr #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_pixel_addr (
    .clk              (clk),
    .rst              (rst),
    .row_stride_bytes (row_stride_bytes),
    .bytes_per_pixel  (bytes_per_pixel),
    .pix_valid        (pix_valid),
    .pix_ready        (pix_ready),
    .pix              (pix),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast)
  );

endmodule

`default_nettype wire

### dv/line_pixel_checker.sv
// watches the line rasterizer channels, predicts each pixel word and compares
module line_pixel_checker #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [151:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending
);
  import lrdi_pkg::*;

  localparam longint DEPTH_MAX = 64'sd2147483647;
  localparam longint DEPTH_MIN = -64'sd2147483648;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] offset;
    logic [31:0] depth;
    logic        vis;
    logic        last;
  } pixel_t;

  // configuration copy
  logic [15:0]        row_stride;
  logic [3:0]         pix_bytes;

  // line stepper state
  logic signed [15:0] major_pos;
  logic signed [15:0] minor_pos;
  logic signed [15:0] major_end;
  logic [15:0]        span_major;
  logic [15:0]        span_minor;
  logic signed [17:0] step_err;
  logic signed [31:0] depth_acc;
  logic signed [31:0] depth_inc;
  logic               swapped;
  logic               step_down;
  logic               line_on;

  pixel_t pixels_due[$];

  // advance the line by one input word; returns 1 when a pixel comes out
  function automatic bit step_line(input logic kind, input logic [151:0] d,
                                   output pixel_t px);
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [17:0] err;
    longint             off;
    longint             dsum;
    bit                 vis;
    bit                 last;
    px = '{default: '0};
    if (kind == KIND_START) begin
      major_pos  = d[15:0];
      minor_pos  = d[31:16];
      major_end  = d[47:32];
      span_major = d[63:48];
      span_minor = d[79:64];
      swapped    = d[80];
      step_down  = d[81];
      depth_acc  = d[113:82];
      depth_inc  = d[145:114];
      step_err   = {3'b000, span_major[15:1]};
      line_on    = (major_pos <= major_end);
      return 1'b0;
    end
    if (!line_on) return 1'b0;

    sx = swapped ? minor_pos : major_pos;
    sy = swapped ? major_pos : minor_pos;
    off = 0;
    vis = 1'b0;
    if (sx >= 0 && sy >= 0 && sx < SCREEN_WIDTH && sy < SCREEN_HEIGHT) begin
      off = longint'(sy) * longint'(row_stride) + longint'(sx) * longint'(pix_bytes);
      vis = off < longint'(row_stride) * SCREEN_HEIGHT;
      if (!vis) off = 0;
    end
    last = (major_pos == major_end);
    px.x      = sx;
    px.y      = sy;
    px.offset = off[31:0];
    px.depth  = depth_acc;
    px.vis    = vis;
    px.last   = last;

    // error term and minor step, both wrapping
    err = step_err - {2'b00, span_minor};
    if (err < 0) begin
      minor_pos = step_down ? minor_pos - 16'sd1 : minor_pos + 16'sd1;
      err = err + {2'b00, span_major};
    end
    step_err = err;

    // saturating depth add
    dsum = longint'(depth_acc) + longint'(depth_inc);
    if (dsum > DEPTH_MAX) dsum = DEPTH_MAX;
    if (dsum < DEPTH_MIN) dsum = DEPTH_MIN;
    depth_acc = dsum[31:0];

    if (last) line_on = 1'b0;
    else major_pos = major_pos + 16'sd1;
    return 1'b1;
  endfunction

  function automatic int cmp_field(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    int     errs;
    errs = 0;
    if (rst) begin
      row_stride = ROW_STRIDE_RESET;
      pix_bytes  = BYTES_PER_PIXEL_RESET;
      major_pos  = '0;
      minor_pos  = '0;
      major_end  = '0;
      span_major = '0;
      span_minor = '0;
      step_err   = '0;
      depth_acc  = '0;
      depth_inc  = '0;
      swapped    = 1'b0;
      step_down  = 1'b0;
      line_on    = 1'b0;
      pixels_due.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROW_STRIDE:      row_stride = cfg_data;
          REG_BYTES_PER_PIXEL: pix_bytes  = cfg_data[3:0];
          default: ;
        endcase
      end
      // pixel words leaving the block
      if (m_tvalid && m_tready) begin
        got.x      = m_tdata[15:0];
        got.y      = m_tdata[31:16];
        got.offset = m_tdata[63:32];
        got.depth  = m_tdata[95:64];
        got.vis    = m_tdata[96];
        got.last   = m_tlast;
        if (pixels_due.size() == 0) begin
          $error("pixel word with no pixel expected: x %0h y %0h", got.x, got.y);
          errs++;
        end else begin
          want = pixels_due.pop_front();
          errs += cmp_field("pixel_x", want.x, got.x);
          errs += cmp_field("pixel_y", want.y, got.y);
          errs += cmp_field("byte_offset", want.offset, got.offset);
          errs += cmp_field("depth", want.depth, got.depth);
          errs += cmp_field("visible", want.vis, got.vis);
          errs += cmp_field("last", want.last, got.last);
        end
      end
      // input words entering the block
      if (s_tvalid && s_tready) begin
        if (step_line(s_tuser, s_tdata, want)) pixels_due.push_back(want);
      end
    end
    fail_count <= fail_count + errs;
    pending    <= pixels_due.size();
  end

endmodule

### dv/testbench.sv
// top of the line rasterizer testbench: clock, reset, stimulus and verdict
module testbench;
  import lrdi_pkg::*;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 768;
  localparam int ITEM_TARGET   = 1100;
  localparam int PHASES        = 6;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic signed [15:0] major0;
    logic signed [15:0] minor0;
    logic signed [15:0] major1;
    logic [15:0]        span_maj;
    logic [15:0]        span_min;
    logic               steep;
    logic               down;
    logic [31:0]        z0;
    logic [31:0]        dz;
  } line_t;

  logic         clk;
  logic         rst       = 1'b1;
  logic         cfg_valid = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [15:0]  cfg_data  = '0;
  logic         s_tvalid  = 1'b0;
  logic [151:0] s_tdata   = '0;
  logic         s_tuser   = 1'b0;
  logic         m_tready  = 1'b0;
  wire          cfg_ready;
  wire          s_tready;
  wire          m_tvalid;
  wire  [103:0] m_tdata;
  wire          m_tlast;

  int fail_count;
  int pending;
  int sent;
  bit tx_burst;
  bit long_hold;
  bit hold_seen;

  line_rasterizer_depth_interp_unit #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  line_pixel_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) i_pixel_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [151:0] pack_line(input line_t l);
    return {6'b0, l.dz, l.z0, l.down, l.steep, l.span_min, l.span_maj,
            l.major1, l.minor0, l.major0};
  endfunction

  // offer one word, hold it until taken
  task automatic send_word(input logic kind, input logic [151:0] data);
    int g;
    g = tx_burst ? 0 : pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic start_line(input line_t l);
    send_word(KIND_START, pack_line(l));
  endtask

  task automatic step_pixels(input int n);
    repeat (n) send_word(KIND_STEP, 152'({$urandom, $urandom, $urandom, $urandom, $urandom}));
  endtask

  // stop offering and wait for every pixel plus the pipeline tail
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] stride, input logic [3:0] bpp);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROW_STRIDE;
    cfg_data  <= stride;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_BYTES_PER_PIXEL;
    cfg_data  <= {12'($urandom), bpp};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic line_t make_line(input int maj0, input int min0, input int maj1,
                                      input int smaj, input int smin, input bit steep,
                                      input bit down, input logic [31:0] z0,
                                      input logic [31:0] dz);
    line_t l;
    l.major0   = 16'(maj0);
    l.minor0   = 16'(min0);
    l.major1   = 16'(maj1);
    l.span_maj = 16'(smaj);
    l.span_min = 16'(smin);
    l.steep    = steep;
    l.down     = down;
    l.z0       = z0;
    l.dz       = dz;
    return l;
  endfunction

  // random line, mostly well formed, some noise; n is the step count to send
  task automatic rand_line(output line_t l, output int n);
    int r;
    int len;
    r = $urandom_range(0, 99);
    l.steep = $urandom_range(0, 1);
    l.down  = $urandom_range(0, 1);
    l.z0    = $urandom;
    l.dz    = ($urandom_range(0, 3) == 0) ? $urandom
                                          : 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
    if (r < 8) begin
      // fully random fields, usually a huge or empty line
      l.major0   = 16'($urandom);
      l.minor0   = 16'($urandom);
      l.major1   = 16'($urandom);
      l.span_maj = 16'($urandom);
      l.span_min = 16'($urandom);
      n = $urandom_range(0, 4);
    end else begin
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 20);
      l.major0   = 16'($urandom_range(0, 1150)) - 16'd40;
      l.minor0   = 16'($urandom_range(0, 1150)) - 16'd40;
      l.major1   = l.major0 + 16'(len);
      l.span_maj = 16'(len);
      l.span_min = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(len, 65535))
                                               : 16'($urandom_range(0, len));
      if (r < 80) n = len + 1;
      else if (r < 88) n = $urandom_range(0, len);
      else if (r < 94) n = len + 1 + $urandom_range(1, 3);
      else begin
        // empty line: end before start
        l.major1 = l.major0 - 16'($urandom_range(1, 5));
        n = $urandom_range(0, 2);
      end
    end
  endtask

  // receiver: random stalls, free-running stretches, and one long hold-off on request
  initial begin
    int k;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (long_hold && !hold_seen) begin
        hold_seen = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (!long_hold) hold_seen = 1'b0;
        k = $urandom_range(0, 9);
        m_tready <= 1'b1;
        repeat ((k < 2) ? 40 : $urandom_range(1, 6)) @(posedge clk);
        if (k >= 2) begin
          m_tready <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  // stimulus
  initial begin
    line_t l;
    int    n;
    int    phase;
    int    goal;
    logic [15:0] strides [PHASES] = '{16'd1024, 16'd0, 16'd65535, 16'd2048, 16'd4096, 16'd0};
    logic [3:0]  sizes   [PHASES] = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd4, 4'd0};
    strides[PHASES-1] = 16'($urandom);
    sizes[PHASES-1]   = 4'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: step with no line, empty line
    step_pixels(1);
    start_line(make_line(10, 0, 5, 5, 0, 0, 0, 32'h0, 32'h0));
    step_pixels(1);
    // short flat line
    start_line(make_line(0, 0, 3, 3, 2, 0, 0, 32'h0001_0000, 32'h0000_8000));
    step_pixels(4);
    // steep line at the screen corner, depth saturating high
    start_line(make_line(766, 1023, 767, 1, 1, 1, 1, 32'h7FFF_0000, 32'h4000_0000));
    step_pixels(2);
    // extreme coordinates: minor wraps, error term wraps, depth saturating low
    start_line(make_line(32765, -32768, 32767, 0, 65535, 0, 1, 32'h8000_1000,
                         32'h8000_0000));
    step_pixels(3);
    // long line cut short by a new start crossing the right edge
    start_line(make_line(-5, 0, 32767, 65535, 65535, 0, 0, 32'h1234_5678, 32'hFFFF_0000));
    step_pixels(2);
    start_line(make_line(1020, 700, 1025, 5, 3, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001));
    step_pixels(6);

    // random phases, each under its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      set_config(strides[phase], sizes[phase]);
      if (phase == 3) begin
        // long output hold-off while words keep coming
        tx_burst = 1'b1;
        start_line(make_line(0, 100, 149, 149, 60, 0, 0, 32'h0, 32'h0000_2000));
        long_hold = 1'b1;
        step_pixels(150);
        long_hold = 1'b0;
      end
      goal = ITEM_TARGET * (phase + 1) / PHASES;
      while (sent < goal) begin
        tx_burst = ($urandom_range(0, 4) == 0);
        rand_line(l, n);
        start_line(l);
        step_pixels(n);
      end
      tx_burst = 1'b0;
    end

    settle_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
